/* src/lqpi_pkg.sv */
// Shared constants of the luma quarter-pel interpolator.
package lqpi_pkg;

	// Size of the stored reference plane.
	localparam int PLANE_WIDTH  = 128;
	localparam int PLANE_HEIGHT = 128;
	localparam int PLANE_DEPTH  = PLANE_WIDTH * PLANE_HEIGHT;
	localparam int ADDR_W       = $clog2(PLANE_DEPTH);
	localparam int COL_W        = $clog2(PLANE_WIDTH);
	localparam int ROW_W        = $clog2(PLANE_HEIGHT);

	// Field widths of the channels.
	localparam int POS_W    = 7;
	localparam int MV_W     = 14;
	localparam int SAMPLE_W = 8;
	localparam int REG_W    = 8;
	localparam int IDX_W    = 8;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;

	// Signed width of a sample coordinate before clamping to the plane.
	localparam int CRD_W = 14;

	// Operation carried in the input tuser.
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PREDICT = 1'b1;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_REF_WIDTH  = 8'd0;
	localparam logic [IDX_W-1:0] REG_REF_HEIGHT = 8'd1;

endpackage

/* src/lqpi_ram.sv */
// Generic single-port RAM with a registered read.
module lqpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

/* src/luma_quarter_pel_interpolator.sv */
// Top level of the luma quarter-pel interpolator: sequencer, shared filter unit and plane RAM.
//
// The block holds a reference luma plane in a single-port RAM and answers predict
// requests with one interpolated sample each. Items arrive on the s_ stream channel;
// tuser selects a load (write one plane sample) or a predict (one destination pixel
// plus a quarter-pel motion vector). A load produces no output transfer and is written
// in the cycle it is accepted, so the next item may follow at once.
// A predict reads 1, 6 or 12 plane samples, one per cycle through the single RAM port,
// and feeds each into one shared multiply-accumulate unit of the 6-tap filter. After
// the reads the sequencer passes through a drain and a done state before loading the
// result register; the reads through the single RAM port set the length of a predict.
// The input is not ready while a predict is in progress.
// Results leave on the m_ channel from an output register, tlast echoing the block
// marker. If the receiver stalls, the block still accepts loads and starts the next
// predict, and only waits to deliver its result until the register is free.
// The configuration channel sets the plane area used for edge clamping; it is always
// ready and must only be written while the block is idle.
// Reset clears the sequencer, the output valid and sets both extents to the full plane.
// The plane content is undefined after reset until loaded.
module luma_quarter_pel_interpolator (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream. tdata from bit 0: pos_x[6:0], pos_y[13:7], motion_x[27:14],
	// motion_y[41:28], sample_value[49:42], zero fill [55:50].
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lqpi_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                               s_tlast,   // block_last
	input  logic                               s_tuser,   // op
	// Output stream. tdata from bit 0: pred_sample[7:0], out_x[14:8], out_y[21:15],
	// zero fill [23:22].
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lqpi_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                               m_tlast,   // out_last
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lqpi_pkg::IDX_W-1:0]         cfg_index,
	input  logic [lqpi_pkg::REG_W-1:0]         cfg_data
);

	localparam int CRD_W = lqpi_pkg::CRD_W;
	localparam int COL_W = lqpi_pkg::COL_W;
	localparam int ROW_W = lqpi_pkg::ROW_W;
	localparam int POS_W = lqpi_pkg::POS_W;
	localparam int SMP_W = lqpi_pkg::SAMPLE_W;
	localparam int ACC_W = 16;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	// Interpolation modes.
	localparam logic [1:0] MODE_FULL = 2'd0;
	localparam logic [1:0] MODE_HOR  = 2'd1;
	localparam logic [1:0] MODE_VER  = 2'd2;
	localparam logic [1:0] MODE_DIAG = 2'd3;

	localparam logic [3:0] LAST_FULL = 4'd0;
	localparam logic [3:0] LAST_ONE  = 4'd5;
	localparam logic [3:0] LAST_TWO  = 4'd11;
	localparam logic [3:0] ROW_TAPS  = 4'd6;
	localparam logic [2:0] TAP_FIRST = 3'd0;
	localparam logic [2:0] TAP_LAST  = 3'd5;

	// Input field unpacking.
	logic [POS_W-1:0]                  in_pos_x;
	logic [POS_W-1:0]                  in_pos_y;
	logic signed [lqpi_pkg::MV_W-1:0]  in_motion_x;
	logic signed [lqpi_pkg::MV_W-1:0]  in_motion_y;
	logic [SMP_W-1:0]                  in_sample;

	assign in_pos_x    = s_tdata[6:0];
	assign in_pos_y    = s_tdata[13:7];
	assign in_motion_x = s_tdata[27:14];
	assign in_motion_y = s_tdata[41:28];
	assign in_sample   = s_tdata[49:42];

	logic [1:0] state_q;
	logic       in_xfer;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	// Configuration registers.
	logic [lqpi_pkg::REG_W-1:0] ref_width_q;
	logic [lqpi_pkg::REG_W-1:0] ref_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_width_q  <= lqpi_pkg::REG_W'(lqpi_pkg::PLANE_WIDTH);
			ref_height_q <= lqpi_pkg::REG_W'(lqpi_pkg::PLANE_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == lqpi_pkg::REG_REF_WIDTH) begin
				ref_width_q <= cfg_data;
			end else if (cfg_index == lqpi_pkg::REG_REF_HEIGHT) begin
				ref_height_q <= cfg_data;
			end
		end
	end

	// Largest usable column and row: a zero extent counts as one, an extent beyond
	// the plane counts as the plane size.
	logic [COL_W-1:0] col_max;
	logic [ROW_W-1:0] row_max;

	always_comb begin
		if (ref_width_q == '0) begin
			col_max = '0;
		end else if (int'(ref_width_q) >= lqpi_pkg::PLANE_WIDTH) begin
			col_max = COL_W'(lqpi_pkg::PLANE_WIDTH - 1);
		end else begin
			col_max = COL_W'(int'(ref_width_q) - 1);
		end
		if (ref_height_q == '0) begin
			row_max = '0;
		end else if (int'(ref_height_q) >= lqpi_pkg::PLANE_HEIGHT) begin
			row_max = ROW_W'(lqpi_pkg::PLANE_HEIGHT - 1);
		end else begin
			row_max = ROW_W'(int'(ref_height_q) - 1);
		end
	end

	// Decode of a predict request at acceptance.
	logic [1:0]              frac_x;
	logic [1:0]              frac_y;
	logic signed [CRD_W-1:0] mvx_ext;
	logic signed [CRD_W-1:0] mvy_ext;
	logic signed [CRD_W-1:0] base_x;
	logic signed [CRD_W-1:0] base_y;
	logic [1:0]              mode_d;

	assign frac_x  = in_motion_x[1:0];
	assign frac_y  = in_motion_y[1:0];
	assign mvx_ext = CRD_W'(in_motion_x);
	assign mvy_ext = CRD_W'(in_motion_y);
	// Floor of the quarter-pel vector is an arithmetic shift.
	assign base_x  = $signed(CRD_W'(in_pos_x)) + (mvx_ext >>> 2);
	assign base_y  = $signed(CRD_W'(in_pos_y)) + (mvy_ext >>> 2);

	always_comb begin
		unique case ({frac_x != 2'd0, frac_y != 2'd0})
			2'b00:   mode_d = MODE_FULL;
			2'b10:   mode_d = MODE_HOR;
			2'b01:   mode_d = MODE_VER;
			default: mode_d = MODE_DIAG;
		endcase
	end

	// Request registers.
	logic signed [CRD_W-1:0] base_x_q;
	logic signed [CRD_W-1:0] base_y_q;
	logic [1:0]              mode_q;
	logic [3:0]              last_k_q;
	logic [2:0]              full_tap_q;
	logic                    half_q;
	logic                    next_row_q;
	logic [POS_W-1:0]        dst_x_q;
	logic [POS_W-1:0]        dst_y_q;
	logic                    dst_last_q;
	logic [3:0]              k_q;

	// Sample coordinate of the current fetch.
	logic                    row1;
	logic [2:0]              tap;
	logic signed [CRD_W-1:0] tap_off;
	logic signed [CRD_W-1:0] smp_x;
	logic signed [CRD_W-1:0] smp_y;
	logic [COL_W-1:0]        clp_x;
	logic [ROW_W-1:0]        clp_y;

	always_comb begin
		row1    = (k_q >= ROW_TAPS);
		tap     = row1 ? 3'(k_q - ROW_TAPS) : k_q[2:0];
		tap_off = $signed(CRD_W'(tap)) - $signed(CRD_W'(2));
		smp_x   = base_x_q;
		smp_y   = base_y_q;
		unique case (mode_q)
			MODE_FULL: begin
			end
			MODE_HOR: begin
				smp_x = base_x_q + tap_off;
			end
			MODE_VER: begin
				smp_y = base_y_q + tap_off;
			end
			default: begin
				// Both fractions: the second row is py again or py+1.
				smp_x = base_x_q + tap_off;
				if (row1 && next_row_q) begin
					smp_y = base_y_q + $signed(CRD_W'(1));
				end
			end
		endcase
		if (smp_x < 0) begin
			clp_x = '0;
		end else if (smp_x > $signed(CRD_W'(col_max))) begin
			clp_x = col_max;
		end else begin
			clp_x = smp_x[COL_W-1:0];
		end
		if (smp_y < 0) begin
			clp_y = '0;
		end else if (smp_y > $signed(CRD_W'(row_max))) begin
			clp_y = row_max;
		end else begin
			clp_y = smp_y[ROW_W-1:0];
		end
	end

	// Plane RAM port: loads write at acceptance, the sequencer reads otherwise.
	logic                        ram_en;
	logic                        ram_we;
	logic [lqpi_pkg::ADDR_W-1:0] ram_addr;
	logic [SMP_W-1:0]            ram_rdata;
	logic                        load_ok;

	assign load_ok = (int'(in_pos_x) < lqpi_pkg::PLANE_WIDTH)
		&& (int'(in_pos_y) < lqpi_pkg::PLANE_HEIGHT);

	always_comb begin
		ram_we   = in_xfer && (s_tuser == lqpi_pkg::OP_LOAD) && load_ok;
		ram_en   = ram_we || (state_q == ST_RUN);
		if (state_q == ST_RUN) begin
			ram_addr = lqpi_pkg::ADDR_W'(int'(clp_y) * lqpi_pkg::PLANE_WIDTH + int'(clp_x));
		end else begin
			ram_addr = lqpi_pkg::ADDR_W'(int'(in_pos_y) * lqpi_pkg::PLANE_WIDTH
				+ int'(in_pos_x));
		end
	end

	lqpi_ram #(
		.WIDTH (SMP_W),
		.DEPTH (lqpi_pkg::PLANE_DEPTH)
	) u_plane (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_sample),
		.rdata (ram_rdata)
	);

	// Read-side stage: tap position travels alongside the RAM read.
	logic       rd_valid_s1;
	logic [2:0] tap_s1;
	logic       row1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_RUN);
		end
	end

	always_ff @(posedge clk) begin
		tap_s1  <= tap;
		row1_s1 <= row1;
	end

	// Shared filter unit: one tap of (1,-5,20,20,-5,1) per cycle, done with shifts and adds.
	function automatic logic [SMP_W-1:0] clip_filter(logic signed [ACC_W-1:0] s);
		logic signed [ACC_W-1:0] t;
		t = s >>> 5;
		if (s < 0) begin
			clip_filter = '0;
		end else if (t > $signed(ACC_W'(255))) begin
			clip_filter = 8'd255;
		end else begin
			clip_filter = t[SMP_W-1:0];
		end
	endfunction

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [ACC_W-1:0] acc_term;
	logic signed [ACC_W-1:0] acc_next;
	logic signed [ACC_W-1:0] smp_ext;
	logic [SMP_W-1:0]        r0_q;
	logic [SMP_W-1:0]        r1_q;
	logic [SMP_W-1:0]        full_q;

	always_comb begin
		smp_ext  = $signed(ACC_W'(ram_rdata));
		acc_base = (tap_s1 == TAP_FIRST) ? $signed(ACC_W'(16)) : acc_q;
		unique case (tap_s1)
			3'd1, 3'd4: acc_term = -((smp_ext <<< 2) + smp_ext);
			3'd2, 3'd3: acc_term = (smp_ext <<< 4) + (smp_ext <<< 2);
			default:    acc_term = smp_ext;
		endcase
		acc_next = acc_base + acc_term;
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			acc_q <= acc_next;
			if (tap_s1 == TAP_LAST) begin
				if (row1_s1) begin
					r1_q <= clip_filter(acc_next);
				end else begin
					r0_q <= clip_filter(acc_next);
				end
			end
			// The nearer full sample of a quarter position is one of the filter taps.
			if (!row1_s1 && (tap_s1 == full_tap_q)) begin
				full_q <= ram_rdata;
			end
		end
	end

	// Final selection and rounding average.
	logic [SMP_W:0]   avg_sum;
	logic [SMP_W-1:0] pred;

	always_comb begin
		avg_sum = (SMP_W+1)'(r0_q) + ((mode_q == MODE_DIAG) ? (SMP_W+1)'(r1_q)
			: (SMP_W+1)'(full_q)) + (SMP_W+1)'(1);
		unique case (mode_q)
			MODE_FULL: pred = full_q;
			MODE_HOR, MODE_VER: pred = half_q ? r0_q : avg_sum[SMP_W:1];
			default: pred = avg_sum[SMP_W:1];
		endcase
	end

	// Sequencer.
	logic out_free;
	logic m_tvalid_q;
	logic [SMP_W-1:0] m_pred_q;
	logic [POS_W-1:0] m_x_q;
	logic [POS_W-1:0] m_y_q;
	logic             m_last_q;

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (in_xfer && (s_tuser == lqpi_pkg::OP_PREDICT)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					k_q <= k_q + 4'd1;
					if (k_q == last_k_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				default: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (s_tuser == lqpi_pkg::OP_PREDICT)) begin
			base_x_q   <= base_x;
			base_y_q   <= base_y;
			mode_q     <= mode_d;
			dst_x_q    <= in_pos_x;
			dst_y_q    <= in_pos_y;
			dst_last_q <= s_tlast;
			next_row_q <= (frac_y != 2'd1);
			unique case (mode_d)
				MODE_FULL: begin
					last_k_q   <= LAST_FULL;
					full_tap_q <= TAP_FIRST;
					half_q     <= 1'b0;
				end
				MODE_HOR: begin
					last_k_q   <= LAST_ONE;
					full_tap_q <= (frac_x == 2'd1) ? 3'd2 : 3'd3;
					half_q     <= (frac_x == 2'd2);
				end
				MODE_VER: begin
					last_k_q   <= LAST_ONE;
					full_tap_q <= (frac_y == 2'd1) ? 3'd2 : 3'd3;
					half_q     <= (frac_y == 2'd2);
				end
				default: begin
					last_k_q   <= LAST_TWO;
					full_tap_q <= TAP_FIRST;
					half_q     <= 1'b0;
				end
			endcase
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_pred_q <= pred;
			m_x_q    <= dst_x_q;
			m_y_q    <= dst_y_q;
			m_last_q <= dst_last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_y_q, m_x_q, m_pred_q};
	assign m_tlast  = m_last_q;

endmodule

/* src/lqpi_checker.sv */
// Port-level assertions of the luma quarter-pel interpolator, bound to its top level.
module lqpi_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [lqpi_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                            s_tlast,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [lqpi_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            m_tlast,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [lqpi_pkg::IDX_W-1:0]      cfg_index,
	input logic [lqpi_pkg::REG_W-1:0]      cfg_data
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// A predict keeps the input busy for the following cycle.
	a_predict_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == lqpi_pkg::OP_PREDICT) |=> !s_tready)
		else $error("input ready straight after a predict transfer");

	// No result appears in the cycle after any item is accepted while no result is pending.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared without processing time");

	// A new result is only produced while the input was held off.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result raised while the block was idle");

	// The zero fill of the result is kept clear.
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:22] == 2'b00))
		else $error("result fill bits set");

endmodule

bind luma_quarter_pel_interpolator lqpi_checker u_lqpi_checker (.*);
